// ===== rtl/tnd_pkg.sv =====
// tnd_pkg: shared types and constants for the tree node distance block
// widths of node, step and distance fields, controller states, command and status structs
// no dependencies
package tnd_pkg;

  localparam int unsigned NODE_W      = 10;
  localparam int unsigned TABLE_DEPTH = 1 << NODE_W;
  localparam int unsigned DIST_W      = 11;
  localparam int unsigned IN_DATA_W   = 24;  // two node fields padded to bytes
  localparam int unsigned OUT_DATA_W  = 16;  // distance padded to bytes

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_W1_FIRST,
    ST_W1,
    ST_W2_FIRST,
    ST_W2,
    ST_CLR_FIRST,
    ST_CLR,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CUR_A,
    CUR_B,
    CUR_RD
  } cur_sel_e;

  typedef struct packed {
    logic     init_wr;   // clear one row of both tables during the reset sweep
    logic     load_wr;   // write one parent pointer from the input item
    logic     cap_in;    // capture query nodes, clear counters and flags
    cur_sel_e cur_sel;   // source of the current walk node
    logic     anc_wr;    // write mark and step count at the current node
    logic     anc_mark;  // mark value to write
    logic     s_inc;
    logic     t_inc;
    logic     k_inc;
    logic     set_err;
    logic     dist_ld;   // latch distance at the common ancestor
    logic     res_load;  // move finished result to the output register
  } tnd_cmd_t;

  typedef struct packed {
    logic cur_zero;   // current node is the root
    logic s_full;     // first walk used its full step budget
    logic t_full;     // second walk used its full step budget
    logic k_eq_s;     // clearing walk retraced the whole first path
    logic marked;     // node read last cycle is a marked ancestor
    logic init_last;  // reset sweep on its last row
  } tnd_sts_t;

endpackage

// ===== rtl/tnd_dpath.sv =====
// tnd_dpath: parent table, ancestor table, walk counters and result registers
// driven by tnd_ctrl through tnd_cmd_t, reports through tnd_sts_t
// depends on tnd_pkg
module tnd_dpath #(
  parameter int unsigned NODES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tnd_pkg::tnd_cmd_t cmd_i,
  input  tnd_pkg::node_t    node_a_i,
  input  tnd_pkg::node_t    node_b_i,
  output tnd_pkg::tnd_sts_t sts_o,
  output tnd_pkg::dist_t    res_dist_o,
  output logic              res_err_o
);
  import tnd_pkg::*;

  localparam int unsigned CntW = $clog2(NODES + 1);

  node_t            parent_mem [TABLE_DEPTH];
  logic [NODE_W:0]  anc_mem    [TABLE_DEPTH];  // {mark, steps above first node}

  node_t            a_q, b_q, prd_q, cur, init_cnt_q;
  logic [NODE_W:0]  anc_rd_q;
  logic [CntW-1:0]  s_q, t_q, k_q;
  dist_t            dist_q, res_dist_q;
  logic             err_q, res_err_q;

  always_comb begin
    unique case (cmd_i.cur_sel)
      CUR_A:   cur = a_q;
      CUR_B:   cur = b_q;
      CUR_RD:  cur = prd_q;
      default: cur = prd_q;
    endcase
  end

  // parent table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) begin
      parent_mem[init_cnt_q] <= '0;
    end else if (cmd_i.load_wr) begin
      parent_mem[node_b_i] <= node_a_i;
    end
    prd_q <= parent_mem[cur];
  end

  // ancestor marks with step counts
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) begin
      anc_mem[init_cnt_q] <= '0;
    end else if (cmd_i.anc_wr) begin
      anc_mem[cur] <= {cmd_i.anc_mark, NODE_W'(s_q)};
    end
    anc_rd_q <= anc_mem[cur];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= '0;
      s_q        <= '0;
      t_q        <= '0;
      k_q        <= '0;
      err_q      <= 1'b0;
    end else begin
      if (cmd_i.init_wr) begin
        init_cnt_q <= init_cnt_q + 1'b1;
      end
      if (cmd_i.cap_in) begin
        s_q   <= '0;
        t_q   <= '0;
        k_q   <= '0;
        err_q <= 1'b0;
      end else begin
        if (cmd_i.s_inc) s_q <= s_q + 1'b1;
        if (cmd_i.t_inc) t_q <= t_q + 1'b1;
        if (cmd_i.k_inc) k_q <= k_q + 1'b1;
        if (cmd_i.set_err) err_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      a_q    <= node_a_i;
      b_q    <= node_b_i;
      dist_q <= '0;
    end else if (cmd_i.dist_ld) begin
      dist_q <= DIST_W'(anc_rd_q[NODE_W-1:0]) + DIST_W'(t_q);
    end
    if (cmd_i.res_load) begin
      res_dist_q <= dist_q;
      res_err_q  <= err_q;
    end
  end

  assign sts_o.cur_zero  = (cur == '0);
  assign sts_o.s_full    = (s_q == CntW'(NODES));
  assign sts_o.t_full    = (t_q == CntW'(NODES));
  assign sts_o.k_eq_s    = (k_q == s_q);
  assign sts_o.marked    = anc_rd_q[NODE_W];
  assign sts_o.init_last = &init_cnt_q;

  assign res_dist_o = res_dist_q;
  assign res_err_o  = res_err_q;

endmodule

// ===== rtl/tnd_ctrl.sv =====
// tnd_ctrl: state machine sequencing reset sweep, loads, the two walks and the clearing walk
// drives tnd_dpath through tnd_cmd_t and owns the input and output handshakes
// depends on tnd_pkg
module tnd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_opcode_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  tnd_pkg::tnd_sts_t sts_i,
  output tnd_pkg::tnd_cmd_t cmd_o
);
  import tnd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.cur_sel = CUR_RD;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == OP_QUERY) begin
            cmd_o.cap_in = 1'b1;
            state_d      = ST_W1_FIRST;
          end else begin
            cmd_o.load_wr = 1'b1;
          end
        end
      end
      ST_W1_FIRST, ST_W1: begin
        cmd_o.cur_sel  = (state_q == ST_W1_FIRST) ? CUR_A : CUR_RD;
        cmd_o.anc_wr   = 1'b1;
        cmd_o.anc_mark = 1'b1;
        priority if (sts_i.cur_zero) begin
          state_d = ST_W2_FIRST;
        end else if (sts_i.s_full) begin
          cmd_o.set_err = 1'b1;
          state_d       = ST_CLR_FIRST;
        end else begin
          cmd_o.s_inc = 1'b1;
          state_d     = ST_W1;
        end
      end
      ST_W2_FIRST: begin
        cmd_o.cur_sel = CUR_B;
        state_d       = ST_W2;
      end
      ST_W2: begin
        priority if (sts_i.marked) begin
          cmd_o.dist_ld = 1'b1;
          state_d       = ST_CLR_FIRST;
        end else if (sts_i.t_full) begin
          cmd_o.set_err = 1'b1;
          state_d       = ST_CLR_FIRST;
        end else begin
          cmd_o.t_inc = 1'b1;
        end
      end
      ST_CLR_FIRST, ST_CLR: begin
        cmd_o.cur_sel  = (state_q == ST_CLR_FIRST) ? CUR_A : CUR_RD;
        cmd_o.anc_wr   = 1'b1;
        cmd_o.anc_mark = 1'b0;
        if (sts_i.k_eq_s) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_CLR;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.res_load) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/tree_node_distance.sv =====
// tree_node_distance: edge count between two nodes of a rooted tree held as a parent table
// top level, instantiates tnd_ctrl and tnd_dpath
// depends on tnd_pkg
//
//  channel   direction  tdata                              tuser
//  s_axis    in         [9:0] node_a, [19:10] node_b       [0] opcode (0 load, 1 query)
//  m_axis    out        [10:0] distance                    [0] error
//
// loads are taken straight from the idle state, back to back; a query marks the path
// from node_a to the root, climbs from node_b to the first marked node and clears
// the marks before a new item is taken; one parent table read per cycle sets the
// pace; after reset a sweep over all 1024 rows clears both tables before the first
// item is accepted; a finished result waits in the output register while new loads
// go on, and a query that finishes while the output is still full holds there
module tree_node_distance #(
  parameter int unsigned NODES = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [tnd_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,   // [9:0] node_a, [19:10] node_b
  input  logic                             s_axis_tuser_i,   // [0] opcode
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [tnd_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,   // [10:0] distance
  output logic                             m_axis_tuser_o    // [0] error
);
  import tnd_pkg::*;

  tnd_cmd_t cmd;
  tnd_sts_t sts;
  node_t    in_node_a, in_node_b;
  dist_t    res_dist;
  logic     res_err;

  // unpack the item fields
  assign in_node_a = s_axis_tdata_i[NODE_W-1:0];
  assign in_node_b = s_axis_tdata_i[2*NODE_W-1:NODE_W];

  tnd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_opcode_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tnd_dpath #(
    .NODES (NODES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .node_a_i   (in_node_a),
    .node_b_i   (in_node_b),
    .sts_o      (sts),
    .res_dist_o (res_dist),
    .res_err_o  (res_err)
  );

  // distance is zero whenever error is set
  assign m_axis_tdata_o = OUT_DATA_W'(res_dist);
  assign m_axis_tuser_o = res_err;

endmodule
